// File: rtl/assert_macros.svh
// assertion helpers for the checker file bdq_checker.sv
// every macro samples on clk and is switched off while arst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property under reset qualification
`define BDQ_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// condition on one edge implies a consequence on the next edge
`define BDQ_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/bdq_pkg.sv
// bdq_pkg: command and status codes, field widths and the result struct
// of the bounded deque; used by the interfaces and every module but bdq_ram
`timescale 1ns / 1ps

package bdq_pkg;

	// fixed widths of the channel fields
	localparam int CMD_W   = 3;
	localparam int ST_W    = 2;
	localparam int CNT_W   = 4;
	localparam int FIELD_W = 64;

	localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4);

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INS_AFTER  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_AFTER  = 3'd5;

	// status codes
	localparam logic [ST_W-1:0] STAT_OK       = 2'd0;
	localparam logic [ST_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [ST_W-1:0] STAT_EMPTY    = 2'd2;
	localparam logic [ST_W-1:0] STAT_NOTFOUND = 2'd3;

	// one result beat handed from the sequencer to the output register
	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [FIELD_W-1:0] removed_key;
		logic [CNT_W-1:0]   entry_count;
	} res_t;

endpackage

// File: rtl/bdq_ifs.sv
// bdq_req_if and bdq_rsp_if: valid/ready channels of the deque
// depends on bdq_pkg for field widths
`timescale 1ns / 1ps

interface bdq_req_if import bdq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   command;
	logic [FIELD_W-1:0] value;
	logic [FIELD_W-1:0] target;

	modport source (output valid, command, value, target, input ready);
	modport sink (input valid, command, value, target, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [ST_W-1:0]    status;
	logic [FIELD_W-1:0] removed_key;
	logic [CNT_W-1:0]   entry_count;

	modport source (output valid, status, removed_key, entry_count, input ready);
	modport sink (input valid, status, removed_key, entry_count, output ready);
endinterface

// File: rtl/bdq_ram.sv
// bdq_ram: key store of the deque, one write and one registered read per cycle
// standalone, no package use
`timescale 1ns / 1ps

module bdq_ram #(
	parameter int DEPTH    = 8,
	parameter int KEY_BITS = 64,
	localparam int IW      = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                we,
	input  logic [IW-1:0]       addr,
	input  logic [KEY_BITS-1:0] wdata,
	output logic [KEY_BITS-1:0] rdata
);

	logic [KEY_BITS-1:0] mem [DEPTH];
	logic [KEY_BITS-1:0] rd_q;

	// write port and registered read port share the address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
	end

	assign rdata = rd_q;

endmodule

// File: rtl/bdq_seq.sv
// bdq_seq: command sequencer with one slot address adder and one key comparator
// depends on bdq_pkg; drives the key store in bdq_ram
`timescale 1ns / 1ps

module bdq_seq import bdq_pkg::*; #(
	parameter int DEPTH    = 8,
	parameter int KEY_BITS = 64,
	localparam int IW      = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CNT_W-1:0]    cap,
	input  logic                item_valid,
	output logic                item_ready,
	input  logic [CMD_W-1:0]    command,
	input  logic [FIELD_W-1:0]  value,
	input  logic [FIELD_W-1:0]  target,
	output logic                res_valid,
	input  logic                res_ready,
	output res_t                res,
	output logic                ram_we,
	output logic [IW-1:0]       ram_addr,
	output logic [KEY_BITS-1:0] ram_wdata,
	input  logic [KEY_BITS-1:0] ram_rdata
);

	localparam int SW = ((IW > CNT_W) ? IW : CNT_W) + 1;

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_SRCH_RD  = 4'd2;
	localparam logic [3:0] S_SRCH_CMP = 4'd3;
	localparam logic [3:0] S_POP_RD   = 4'd4;
	localparam logic [3:0] S_POP_CAP  = 4'd5;
	localparam logic [3:0] S_INS_RD   = 4'd6;
	localparam logic [3:0] S_INS_WR   = 4'd7;
	localparam logic [3:0] S_INS_FIN  = 4'd8;
	localparam logic [3:0] S_DEL_RD   = 4'd9;
	localparam logic [3:0] S_DEL_WR   = 4'd10;
	localparam logic [3:0] S_DONE     = 4'd11;

	logic [3:0]          state_q, state_d;
	logic [IW-1:0]       head_q, head_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    pos_q, pos_d;
	logic [CNT_W-1:0]    mark_q, mark_d;
	logic [ST_W-1:0]     status_q, status_d;
	logic [KEY_BITS-1:0] removed_q, removed_d;
	logic [CMD_W-1:0]    cmd_q;
	logic [KEY_BITS-1:0] val_q;
	logic [KEY_BITS-1:0] tgt_q;

	logic                accept;
	logic [CNT_W-1:0]    limit;
	logic                full;
	logic                empty;
	logic [CNT_W-1:0]    pos_nx;
	logic [IW-1:0]       head_inc;
	logic [IW-1:0]       head_dec;
	logic [CNT_W-1:0]    apos;
	logic [SW-1:0]       sum;
	logic [IW-1:0]       slot;
	logic                hit;
	logic                use_head_dec;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;

	// effective limit saturates at the store depth
	assign limit = (int'(cap) > DEPTH) ? CNT_W'(DEPTH) : cap;
	assign full  = (count_q >= limit);
	assign empty = (count_q == '0);

	assign pos_nx   = pos_q + CNT_ONE;
	assign head_inc = (head_q == IW'(DEPTH - 1)) ? '0 : head_q + IW'(1);
	assign head_dec = (head_q == '0) ? IW'(DEPTH - 1) : head_q - IW'(1);

	// shared slot adder: position relative to head, wrapped once
	always_comb begin
		apos = pos_q;
		if (state_q == S_DECODE) begin
			apos = count_q;
		end else if (state_q == S_INS_RD || state_q == S_DEL_WR) begin
			apos = pos_q - CNT_ONE;
		end
	end

	assign sum  = SW'(head_q) + SW'(apos);
	assign slot = (sum >= SW'(DEPTH)) ? IW'(sum - SW'(DEPTH)) : IW'(sum);

	assign use_head_dec = (state_q == S_DECODE) && (cmd_q == CMD_PUSH_FRONT);
	assign ram_addr     = use_head_dec ? head_dec : slot;

	// shared key comparator
	assign hit = (ram_rdata == tgt_q);

	// sequencer next state and datapath updates
	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		pos_d     = pos_q;
		mark_d    = mark_q;
		status_d  = status_q;
		removed_d = removed_q;
		ram_we    = 1'b0;
		ram_wdata = val_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					status_d  = STAT_OK;
					removed_d = '0;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DONE;
				case (cmd_q)
					CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
						if (full) begin
							status_d = STAT_FULL;
						end else begin
							ram_we  = 1'b1;
							count_d = count_q + CNT_ONE;
							if (cmd_q == CMD_PUSH_FRONT) begin
								head_d = head_dec;
							end
						end
					end
					CMD_POP_FRONT, CMD_POP_BACK: begin
						if (empty) begin
							status_d = STAT_EMPTY;
						end else begin
							pos_d   = (cmd_q == CMD_POP_BACK) ? count_q - CNT_ONE : '0;
							state_d = S_POP_RD;
						end
					end
					CMD_INS_AFTER: begin
						if (empty) begin
							status_d = STAT_EMPTY;
						end else if (full) begin
							status_d = STAT_FULL;
						end else begin
							pos_d   = '0;
							state_d = S_SRCH_RD;
						end
					end
					CMD_DEL_AFTER: begin
						if (empty) begin
							status_d = STAT_EMPTY;
						end else begin
							pos_d   = '0;
							state_d = S_SRCH_RD;
						end
					end
					default: begin
					end
				endcase
			end
			S_SRCH_RD: begin
				state_d = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				if (hit && cmd_q == CMD_INS_AFTER) begin
					mark_d = pos_nx;
					if (count_q > pos_nx) begin
						pos_d   = count_q;
						state_d = S_INS_RD;
					end else begin
						pos_d   = pos_nx;
						state_d = S_INS_FIN;
					end
				end else if (pos_nx >= count_q) begin
					// match is the last entry for delete, or no match at all
					status_d = STAT_NOTFOUND;
					state_d  = S_DONE;
				end else if (hit) begin
					pos_d   = pos_nx;
					state_d = S_POP_RD;
				end else begin
					pos_d   = pos_nx;
					state_d = S_SRCH_RD;
				end
			end
			S_INS_RD: begin
				state_d = S_INS_WR;
			end
			S_INS_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				pos_d     = pos_q - CNT_ONE;
				state_d   = (pos_q - CNT_ONE == mark_q) ? S_INS_FIN : S_INS_RD;
			end
			S_INS_FIN: begin
				ram_we  = 1'b1;
				count_d = count_q + CNT_ONE;
				state_d = S_DONE;
			end
			S_POP_RD: begin
				state_d = S_POP_CAP;
			end
			S_POP_CAP: begin
				removed_d = ram_rdata;
				state_d   = S_DONE;
				if (cmd_q == CMD_DEL_AFTER && pos_nx < count_q) begin
					pos_d   = pos_nx;
					state_d = S_DEL_RD;
				end else begin
					count_d = count_q - CNT_ONE;
					if (cmd_q == CMD_POP_FRONT) begin
						head_d = head_inc;
					end
				end
			end
			S_DEL_RD: begin
				state_d = S_DEL_WR;
			end
			S_DEL_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
				if (pos_nx < count_q) begin
					pos_d   = pos_nx;
					state_d = S_DEL_RD;
				end else begin
					count_d = count_q - CNT_ONE;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			count_q <= count_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pos_q     <= pos_d;
		mark_q    <= mark_d;
		status_q  <= status_d;
		removed_q <= removed_d;
		if (accept) begin
			cmd_q <= command;
			val_q <= value[KEY_BITS-1:0];
			tgt_q <= target[KEY_BITS-1:0];
		end
	end

	assign res_valid       = (state_q == S_DONE);
	assign res.status      = status_q;
	assign res.removed_key = FIELD_W'(removed_q);
	assign res.entry_count = count_q;

endmodule

// File: rtl/bounded_deque_with_keyed_insert_top.sv
// bounded deque with keyed insert, top level
// depends on bdq_pkg, bdq_ifs, bdq_ram and bdq_seq
`timescale 1ns / 1ps

// Usage:
// req carries one command beat (command, value, target); rsp returns exactly
// one result beat per command (status, removed_key, entry_count), in order.
// cfg_we / cfg_wdata write the capacity register; write it only while idle.
// One command is processed at a time; req.ready is high only while the
// sequencer is idle. Push back / push front write the key directly; pop
// front / pop back read the end entry and capture it. Insert after searches
// from the front for target, shifts the later entries back and writes value
// after the match; delete after searches, removes the entry after the match
// and shifts the later ones forward. The search and shifts go one entry at a
// time through the single key store port and its registered read.
// An output register holds the finished result, so the next command is
// accepted while rsp is stalled; a second result waits until it is taken.
// Reset empties the deque, sets capacity to 4 and drops any pending result.
// The key store itself is not cleared; only data read from live entries is used.

module bounded_deque_with_keyed_insert_top import bdq_pkg::*; #(
	parameter int DEPTH    = 8,
	parameter int KEY_BITS = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata,
	bdq_req_if.sink          req,
	bdq_rsp_if.source        rsp
);

	localparam int IW = $clog2(DEPTH);

	logic [CNT_W-1:0]    cap_q;
	logic                res_valid;
	logic                res_ready;
	res_t                res;
	res_t                out_q;
	logic                out_valid_q;
	logic                ram_we;
	logic [IW-1:0]       ram_addr;
	logic [KEY_BITS-1:0] ram_wdata;
	logic [KEY_BITS-1:0] ram_rdata;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	bdq_seq #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap        (cap_q),
		.item_valid (req.valid),
		.item_ready (req.ready),
		.command    (req.command),
		.value      (req.value),
		.target     (req.target),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.ram_we     (ram_we),
		.ram_addr   (ram_addr),
		.ram_wdata  (ram_wdata),
		.ram_rdata  (ram_rdata)
	);

	bdq_ram #(
		.DEPTH    (DEPTH),
		.KEY_BITS (KEY_BITS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// output register between sequencer and rsp channel
	assign res_ready = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_q.status;
	assign rsp.removed_key = out_q.removed_key;
	assign rsp.entry_count = out_q.entry_count;

endmodule

// File: rtl/bdq_checker.sv
// bdq_checker: port-level assertions for the deque top, attached by bind
// depends on bdq_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bdq_checker import bdq_pkg::*; #(
	parameter int DEPTH = 8
) (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic [ST_W-1:0]    rsp_status,
	input logic [FIELD_W-1:0] rsp_removed_key,
	input logic [CNT_W-1:0]   rsp_entry_count
);

	// one command in flight: ready drops right after a beat is taken
	`BDQ_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "ready held after accept")

	// the count never passes the store depth
	`BDQ_ASSERT(a_count_bound, rsp_valid |-> (int'(rsp_entry_count) <= DEPTH), "count above depth")

	// an empty report always comes with zero entries
	`BDQ_ASSERT(a_empty_zero, (rsp_valid && rsp_status == STAT_EMPTY) |-> (rsp_entry_count == '0), "empty with entries")

	// a failed command removes nothing
	`BDQ_ASSERT(a_fail_nokey, (rsp_valid && rsp_status != STAT_OK) |-> (rsp_removed_key == '0), "key on failure")

	// a stalled result beat holds
	`BDQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_removed_key), "result dropped")

endmodule

bind bounded_deque_with_keyed_insert_top bdq_checker #(
	.DEPTH (DEPTH)
) u_bdq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_removed_key (rsp.removed_key),
	.rsp_entry_count (rsp.entry_count)
);
